@@ design/tbot_pkg.sv @@
package tbot_pkg;

    localparam int CW = 16;           // coordinate width
    localparam int EW = CW + 1;       // edge component width
    localparam int FW = 2 * EW;       // face cross partial product width
    localparam int AW = FW + 1;       // axis component width
    localparam int PW = AW + CW;      // axis component times coordinate
    localparam int SW = PW + 2;       // sum of three products
    localparam int NUM_AXES = 25;
    localparam int NUM_FACES = 4;
    localparam int NUM_EDGES = 6;
    localparam int FIRST_FACE_AXIS = 3;
    localparam int FIRST_CROSS_AXIS = FIRST_FACE_AXIS + NUM_FACES;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [EW-1:0] edge_t;
    typedef logic signed [FW-1:0] fprod_t;
    typedef logic signed [AW-1:0] axis_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [SW-1:0] sum_t;

    // tetrahedron edges as head minus tail vertex
    localparam int EDGE_HEAD [NUM_EDGES] = '{1, 2, 3, 1, 1, 2};
    localparam int EDGE_TAIL [NUM_EDGES] = '{0, 0, 0, 2, 3, 3};

endpackage

@@ design/tetrahedron_box_overlap_test.sv @@
// Separating axis overlap test of a tetrahedron against an axis-aligned box in exact
// integer arithmetic. One tetrahedron/box pair is taken every cycle while the output is
// not stalled; the touching flag comes out at the end of the pipeline (three
// stages build the 25 axes, four project both shapes and compare the intervals). The
// whole pipeline holds while a result waits at the output, so in_ready drops only then.
module tetrahedron_box_overlap_test
    import tbot_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [47:0] vertex_a,
    input  logic [47:0] vertex_b,
    input  logic [47:0] vertex_c,
    input  logic [47:0] vertex_d,
    input  logic [47:0] box_low_corner,
    input  logic [47:0] box_high_corner,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        touching
);

    logic   en;
    logic   axes_valid;
    axis_t  axis [NUM_AXES][3];
    coord_t tet [4][3];
    coord_t box_lo [3];
    coord_t box_hi [3];

    logic   v4_reg, v5_reg, v6_reg, out_valid_reg;
    logic   touching_reg;
    prod_t  pt_reg [NUM_AXES][4][3];
    prod_t  pl_reg [NUM_AXES][3];
    prod_t  ph_reg [NUM_AXES][3];
    sum_t   dot_reg [NUM_AXES][4];
    sum_t   bmin5_reg [NUM_AXES];
    sum_t   bmax5_reg [NUM_AXES];
    sum_t   tmin_reg [NUM_AXES];
    sum_t   tmax_reg [NUM_AXES];
    sum_t   bmin6_reg [NUM_AXES];
    sum_t   bmax6_reg [NUM_AXES];

    prod_t  pt_next [NUM_AXES][4][3];
    prod_t  pl_next [NUM_AXES][3];
    prod_t  ph_next [NUM_AXES][3];
    sum_t   dot_next [NUM_AXES][4];
    sum_t   bmin_next [NUM_AXES];
    sum_t   bmax_next [NUM_AXES];
    sum_t   tmin_next [NUM_AXES];
    sum_t   tmax_next [NUM_AXES];
    logic   touching_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    tbot_axes u_axes (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (in_valid),
        .vertex_a        (vertex_a),
        .vertex_b        (vertex_b),
        .vertex_c        (vertex_c),
        .vertex_d        (vertex_d),
        .box_low_corner  (box_low_corner),
        .box_high_corner (box_high_corner),
        .axes_valid      (axes_valid),
        .axis            (axis),
        .tet             (tet),
        .box_lo          (box_lo),
        .box_hi          (box_hi)
    );

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int v = 0; v < 4; v++)
                begin
                    pt_next[a][v][k] = PW'(axis[a][k]) * PW'(tet[v][k]);
                end
                pl_next[a][k] = PW'(axis[a][k]) * PW'(box_lo[k]);
                ph_next[a][k] = PW'(axis[a][k]) * PW'(box_hi[k]);
            end
        end
    end

    // vertex dot products, and box extent per axis: pick the smaller and larger term per coordinate
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            for (int v = 0; v < 4; v++)
            begin
                dot_next[a][v] = SW'(pt_reg[a][v][0]) + SW'(pt_reg[a][v][1])
                               + SW'(pt_reg[a][v][2]);
            end
            bmin_next[a] = '0;
            bmax_next[a] = '0;
            for (int k = 0; k < 3; k++)
            begin
                if (pl_reg[a][k] <= ph_reg[a][k])
                begin
                    bmin_next[a] = bmin_next[a] + SW'(pl_reg[a][k]);
                    bmax_next[a] = bmax_next[a] + SW'(ph_reg[a][k]);
                end
                else
                begin
                    bmin_next[a] = bmin_next[a] + SW'(ph_reg[a][k]);
                    bmax_next[a] = bmax_next[a] + SW'(pl_reg[a][k]);
                end
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            tmin_next[a] = dot_reg[a][0];
            tmax_next[a] = dot_reg[a][0];
            for (int v = 1; v < 4; v++)
            begin
                if (dot_reg[a][v] < tmin_next[a])
                begin
                    tmin_next[a] = dot_reg[a][v];
                end
                if (dot_reg[a][v] > tmax_next[a])
                begin
                    tmax_next[a] = dot_reg[a][v];
                end
            end
        end
    end

    // a zero axis gives both intervals as zero, so it never separates
    always_comb
    begin
        touching_next = 1'b1;
        for (int a = 0; a < NUM_AXES; a++)
        begin
            if (!(tmin_reg[a] <= bmax6_reg[a] && bmin6_reg[a] <= tmax_reg[a]))
            begin
                touching_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg        <= axes_valid;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg       <= pt_next;
            pl_reg       <= pl_next;
            ph_reg       <= ph_next;
            dot_reg      <= dot_next;
            bmin5_reg    <= bmin_next;
            bmax5_reg    <= bmax_next;
            tmin_reg     <= tmin_next;
            tmax_reg     <= tmax_next;
            bmin6_reg    <= bmin5_reg;
            bmax6_reg    <= bmax5_reg;
            touching_reg <= touching_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign touching  = touching_reg;

endmodule

@@ design/tbot_axes.sv @@
module tbot_axes
    import tbot_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [47:0]  vertex_a,
    input  logic [47:0]  vertex_b,
    input  logic [47:0]  vertex_c,
    input  logic [47:0]  vertex_d,
    input  logic [47:0]  box_low_corner,
    input  logic [47:0]  box_high_corner,
    output logic         axes_valid,
    output axis_t        axis [NUM_AXES][3],
    output coord_t       tet [4][3],
    output coord_t       box_lo [3],
    output coord_t       box_hi [3]
);

    logic   v1_reg, v2_reg, v3_reg;
    coord_t tet1_reg [4][3];
    coord_t tet2_reg [4][3];
    coord_t tet3_reg [4][3];
    coord_t lo1_reg [3], lo2_reg [3], lo3_reg [3];
    coord_t hi1_reg [3], hi2_reg [3], hi3_reg [3];
    edge_t  fe1_reg [NUM_FACES][3];
    edge_t  fe2_reg [NUM_FACES][3];
    edge_t  edge1_reg [NUM_EDGES][3];
    edge_t  edge2_reg [NUM_EDGES][3];
    fprod_t fp_reg [NUM_FACES][6];
    axis_t  axis_reg [NUM_AXES][3];

    coord_t tet_next [4][3];
    coord_t lo_next [3];
    coord_t hi_next [3];
    edge_t  fe1_next [NUM_FACES][3];
    edge_t  fe2_next [NUM_FACES][3];
    edge_t  edge_next [NUM_EDGES][3];
    fprod_t fp_next [NUM_FACES][6];
    axis_t  axis_next [NUM_AXES][3];

    // unpack and take differences
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tet_next[0][k] = vertex_a[k*CW +: CW];
            tet_next[1][k] = vertex_b[k*CW +: CW];
            tet_next[2][k] = vertex_c[k*CW +: CW];
            tet_next[3][k] = vertex_d[k*CW +: CW];
            lo_next[k]     = box_low_corner[k*CW +: CW];
            hi_next[k]     = box_high_corner[k*CW +: CW];
        end
        for (int f = 0; f < NUM_FACES; f++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                fe1_next[f][k] = EW'(tet_next[(f + 2) % 4][k]) - EW'(tet_next[(f + 1) % 4][k]);
                fe2_next[f][k] = EW'(tet_next[(f + 3) % 4][k]) - EW'(tet_next[(f + 1) % 4][k]);
            end
        end
        for (int j = 0; j < NUM_EDGES; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                edge_next[j][k] = EW'(tet_next[EDGE_HEAD[j]][k])
                                - EW'(tet_next[EDGE_TAIL[j]][k]);
            end
        end
    end

    // face normal partial products
    always_comb
    begin
        for (int f = 0; f < NUM_FACES; f++)
        begin
            fp_next[f][0] = FW'(fe1_reg[f][1]) * FW'(fe2_reg[f][2]);
            fp_next[f][1] = FW'(fe1_reg[f][2]) * FW'(fe2_reg[f][1]);
            fp_next[f][2] = FW'(fe1_reg[f][2]) * FW'(fe2_reg[f][0]);
            fp_next[f][3] = FW'(fe1_reg[f][0]) * FW'(fe2_reg[f][2]);
            fp_next[f][4] = FW'(fe1_reg[f][0]) * FW'(fe2_reg[f][1]);
            fp_next[f][5] = FW'(fe1_reg[f][1]) * FW'(fe2_reg[f][0]);
        end
    end

    // build all axes; a unit axis crossed with an edge is a plain rearrangement
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                axis_next[i][k] = (i == k) ? AW'(1) : AW'(0);
            end
        end
        for (int f = 0; f < NUM_FACES; f++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                axis_next[FIRST_FACE_AXIS + f][k] =
                    AW'(fp_reg[f][2*k]) - AW'(fp_reg[f][2*k + 1]);
            end
        end
        for (int j = 0; j < NUM_EDGES; j++)
        begin
            axis_next[FIRST_CROSS_AXIS + j][0]      = AW'(0);
            axis_next[FIRST_CROSS_AXIS + j][1]      = -AW'(edge2_reg[j][2]);
            axis_next[FIRST_CROSS_AXIS + j][2]      = AW'(edge2_reg[j][1]);
            axis_next[FIRST_CROSS_AXIS + 6 + j][0]  = AW'(edge2_reg[j][2]);
            axis_next[FIRST_CROSS_AXIS + 6 + j][1]  = AW'(0);
            axis_next[FIRST_CROSS_AXIS + 6 + j][2]  = -AW'(edge2_reg[j][0]);
            axis_next[FIRST_CROSS_AXIS + 12 + j][0] = -AW'(edge2_reg[j][1]);
            axis_next[FIRST_CROSS_AXIS + 12 + j][1] = AW'(edge2_reg[j][0]);
            axis_next[FIRST_CROSS_AXIS + 12 + j][2] = AW'(0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tet1_reg  <= tet_next;
            tet2_reg  <= tet1_reg;
            tet3_reg  <= tet2_reg;
            lo1_reg   <= lo_next;
            lo2_reg   <= lo1_reg;
            lo3_reg   <= lo2_reg;
            hi1_reg   <= hi_next;
            hi2_reg   <= hi1_reg;
            hi3_reg   <= hi2_reg;
            fe1_reg   <= fe1_next;
            fe2_reg   <= fe2_next;
            edge1_reg <= edge_next;
            edge2_reg <= edge1_reg;
            fp_reg    <= fp_next;
            axis_reg  <= axis_next;
        end
    end

    assign axes_valid = v3_reg;
    assign axis       = axis_reg;
    assign tet        = tet3_reg;
    assign box_lo     = lo3_reg;
    assign box_hi     = hi3_reg;

endmodule

@@ design/tbot_checker.sv @@
module tbot_checker
    import tbot_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic touching
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(touching))
        else $error("held result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled with empty output");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_ready))
        else $error("result appeared without pipeline advance");

endmodule

bind tetrahedron_box_overlap_test tbot_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .touching  (touching)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top
    import tbot_pkg::*;
();

    typedef struct packed {
        logic [47:0] va;
        logic [47:0] vb;
        logic [47:0] vc;
        logic [47:0] vd;
        logic [47:0] blo;
        logic [47:0] bhi;
    } pair_t;

    typedef logic signed [63:0] w_t;
    typedef logic signed [127:0] acc_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [47:0] vertex_a, vertex_b, vertex_c, vertex_d;
    logic [47:0] box_low_corner, box_high_corner;
    logic        out_valid;
    logic        out_ready;
    logic        touching;

    pair_t pending_pairs[$];
    logic  expected_touch[$];
    int    mismatches;
    int    results_seen;
    int    touch_count;
    int    cycle_count;
    bit    stimulus_done;
    int    burst_left;
    int    gap_left;
    int    stall_mode;

    tetrahedron_box_overlap_test dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
        .vertex_d(vertex_d), .box_low_corner(box_low_corner),
        .box_high_corner(box_high_corner),
        .out_valid(out_valid), .out_ready(out_ready), .touching(touching)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic w_t coord(logic [47:0] p, int k);
        logic signed [CW-1:0] c;
        c = p[k*CW +: CW];
        return w_t'(c);
    endfunction

    function automatic acc_t proj(w_t n[3], w_t p[3]);
        return acc_t'(n[0]) * acc_t'(p[0]) + acc_t'(n[1]) * acc_t'(p[1])
             + acc_t'(n[2]) * acc_t'(p[2]);
    endfunction

    function automatic void cross_of(w_t u[3], w_t v[3], output w_t r[3]);
        r[0] = u[1] * v[2] - u[2] * v[1];
        r[1] = u[2] * v[0] - u[0] * v[2];
        r[2] = u[0] * v[1] - u[1] * v[0];
    endfunction

    // separating axis decision over all 25 candidate axes
    function automatic logic shapes_touch(pair_t t);
        w_t   tet[4][3];
        w_t   bx[8][3];
        w_t   ed[6][3];
        w_t   ax[NUM_AXES][3];
        w_t   e1[3], e2[3], unit[3], r[3];
        logic [47:0] vv[4];
        acc_t v, tmin, tmax, bmin, bmax;
        int   n;
        n = 0;
        vv[0] = t.va; vv[1] = t.vb; vv[2] = t.vc; vv[3] = t.vd;
        for (int i = 0; i < 4; i++)
            for (int k = 0; k < 3; k++)
                tet[i][k] = coord(vv[i], k);
        for (int i = 0; i < 8; i++)
            for (int k = 0; k < 3; k++)
                bx[i][k] = i[k] ? coord(t.bhi, k) : coord(t.blo, k);
        for (int i = 0; i < NUM_EDGES; i++)
            for (int k = 0; k < 3; k++)
                ed[i][k] = tet[EDGE_HEAD[i]][k] - tet[EDGE_TAIL[i]][k];
        for (int i = 0; i < 3; i++)
        begin
            for (int k = 0; k < 3; k++)
                ax[n][k] = (i == k) ? 64'sd1 : 64'sd0;
            n++;
        end
        for (int i = 0; i < NUM_FACES; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1[k] = tet[(i + 2) % 4][k] - tet[(i + 1) % 4][k];
                e2[k] = tet[(i + 3) % 4][k] - tet[(i + 1) % 4][k];
            end
            cross_of(e1, e2, r);
            ax[n] = r;
            n++;
        end
        for (int i = 0; i < 3; i++)
        begin
            unit = '{0, 0, 0};
            unit[i] = 1;
            for (int j = 0; j < NUM_EDGES; j++)
            begin
                cross_of(unit, ed[j], r);
                ax[n] = r;
                n++;
            end
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (ax[i][0] == 0 && ax[i][1] == 0 && ax[i][2] == 0)
                continue;
            tmin = proj(ax[i], tet[0]);
            tmax = tmin;
            for (int j = 1; j < 4; j++)
            begin
                v = proj(ax[i], tet[j]);
                if (v < tmin) tmin = v;
                if (v > tmax) tmax = v;
            end
            bmin = proj(ax[i], bx[0]);
            bmax = bmin;
            for (int j = 1; j < 8; j++)
            begin
                v = proj(ax[i], bx[j]);
                if (v < bmin) bmin = v;
                if (v > bmax) bmax = v;
            end
            if (!(tmin <= bmax && bmin <= tmax))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [47:0] pack3(int x, int y, int z);
        logic [15:0] a, b, c;
        a = x[15:0]; b = y[15:0]; c = z[15:0];
        return {c, b, a};
    endfunction

    function automatic int rnd_coord(int span);
        case ($urandom_range(0, 9))
            0: return 32767;
            1: return -32768;
            2: return $urandom;
            default: return $urandom_range(0, 2 * span) - span;
        endcase
    endfunction

    // box near the tetrahedron most of the time, so both outcomes are common
    function automatic pair_t random_pair();
        pair_t t;
        int span, cx, cy, cz, h;
        span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(4, 400);
        cx = $urandom_range(0, 2000) - 1000;
        cy = $urandom_range(0, 2000) - 1000;
        cz = $urandom_range(0, 2000) - 1000;
        if ($urandom_range(0, 7) == 0)
        begin
            t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
            return t;
        end
        t.va = pack3(cx + rnd_coord(span) % 600, cy + rnd_coord(span) % 600,
                     cz + rnd_coord(span) % 600);
        t.vb = pack3(cx + $urandom_range(0, span) - span / 2, cy, cz + $urandom_range(0, span));
        t.vc = pack3(cx, cy + $urandom_range(0, span) - span / 2, cz - $urandom_range(0, span));
        t.vd = ($urandom_range(0, 9) == 0) ? t.va
             : pack3(rnd_coord(span), rnd_coord(span), rnd_coord(span));
        h = $urandom_range(0, span);
        t.blo = pack3(cx + $urandom_range(0, 2 * span) - span, cy - h, cz - h);
        t.bhi = pack3(cx + h, cy + $urandom_range(0, 2 * span) - span, cz + h);
        if ($urandom_range(0, 5) == 0)
            t.bhi = pack3(rnd_coord(32767), rnd_coord(32767), rnd_coord(32767));
        return t;
    endfunction

    function automatic pair_t make_pair(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                                        logic [47:0] d, logic [47:0] lo, logic [47:0] hi);
        pair_t t;
        t.va = a; t.vb = b; t.vc = c; t.vd = d; t.blo = lo; t.bhi = hi;
        return t;
    endfunction

    initial
    begin
        logic [47:0] mx, mn;
        mx = pack3(32767, 32767, 32767);
        mn = pack3(-32768, -32768, -32768);
        // overlapping, separated, extremes, degenerate faces, inverted box
        pending_pairs.push_back(make_pair(pack3(0, 0, 0), pack3(10, 0, 0), pack3(0, 10, 0),
            pack3(0, 0, 10), pack3(1, 1, 1), pack3(5, 5, 5)));
        pending_pairs.push_back(make_pair(pack3(0, 0, 0), pack3(10, 0, 0), pack3(0, 10, 0),
            pack3(0, 0, 10), pack3(4, 4, 4), pack3(9, 9, 9)));
        pending_pairs.push_back(make_pair(pack3(0, 0, 0), pack3(10, 0, 0), pack3(0, 10, 0),
            pack3(0, 0, 10), pack3(20, 0, 0), pack3(30, 5, 5)));
        pending_pairs.push_back(make_pair(pack3(0, 0, 0), pack3(10, 0, 0), pack3(0, 10, 0),
            pack3(0, 0, 10), pack3(10, 0, 0), pack3(12, 3, 3)));
        pending_pairs.push_back(make_pair(mn, mx, pack3(-32768, 32767, -32768),
            pack3(32767, -32768, 32767), mn, mx));
        pending_pairs.push_back(make_pair(mx, mn, mx, mn, mx, mn));
        pending_pairs.push_back(make_pair(mx, mx, mx, mx, mx, mx));
        pending_pairs.push_back(make_pair(mn, mn, mn, mn, mx, mx));
        pending_pairs.push_back(make_pair(mn, mn, mn, mn, mn, mn));
        pending_pairs.push_back(make_pair(pack3(5, 5, 5), pack3(5, 5, 5), pack3(5, 5, 5),
            pack3(5, 5, 5), pack3(0, 0, 0), pack3(9, 9, 9)));
        pending_pairs.push_back(make_pair(pack3(0, 0, 0), pack3(10, 0, 0), pack3(20, 0, 0),
            pack3(30, 0, 0), pack3(5, -1, -1), pack3(6, 1, 1)));
        pending_pairs.push_back(make_pair(pack3(0, 0, 0), pack3(10, 0, 0), pack3(0, 10, 0),
            pack3(0, 0, 10), pack3(5, 5, 5), pack3(1, 1, 1)));
        pending_pairs.push_back(make_pair(pack3(0, 0, 0), pack3(10, 0, 0), pack3(0, 10, 0),
            pack3(0, 0, 10), pack3(30, 30, 30), pack3(-30, -30, -30)));
        pending_pairs.push_back(make_pair(pack3(-32768, 0, 0), pack3(32767, 1, 0),
            pack3(0, 32767, -32768), pack3(1, -32768, 32767), pack3(-5, -5, -5),
            pack3(5, 5, 5)));
        pending_pairs.push_back(make_pair(48'h0, 48'hFFFF_FFFF_FFFF, 48'h5555_5555_5555,
            48'hAAAA_AAAA_AAAA, 48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF));
        for (int i = 0; i < 1450; i++)
            pending_pairs.push_back(random_pair());
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // driver: bursts of random length with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            {vertex_a, vertex_b, vertex_c, vertex_d, box_low_corner, box_high_corner} <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                expected_touch.push_back(shapes_touch({vertex_a, vertex_b, vertex_c,
                    vertex_d, box_low_corner, box_high_corner}));
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pairs.size() == 0)
                in_valid <= 1'b0;
            else
            begin
                pair_t t;
                t = pending_pairs.pop_front();
                {vertex_a, vertex_b, vertex_c, vertex_d, box_low_corner, box_high_corner} <= t;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver stall pattern: free-running, periodic, or random phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= (cycle_count % 3) != 0;
                default: out_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_touch.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none, actual touching=%0b",
                         $time, touching);
                mismatches++;
            end
            else
            begin
                logic e;
                e = expected_touch.pop_front();
                if (touching !== e)
                begin
                    $display("%0t: touching expected %0b actual %0b", $time, e, touching);
                    mismatches++;
                end
                touch_count += e;
            end
            results_seen++;
        end
    end

    initial
    begin
        mismatches = 0;
        results_seen = 0;
        touch_count = 0;
        cycle_count = 0;
        stimulus_done = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        wait (pending_pairs.size() == 0 && !in_valid);
        while (expected_touch.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Checked %0d tetrahedron/box pairs, %0d touching and %0d separated.",
                 results_seen, touch_count, results_seen - touch_count);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
design/tbot_pkg.sv
design/tbot_axes.sv
design/tetrahedron_box_overlap_test.sv
design/tbot_checker.sv
tb/sv/tb_top.sv
